// ===== rtl/core/hlts_pkg.sv =====
// Shared types, constants and the microcode program of the Holt trend smoother.
// Used by hlts_mul_unit and holt_linear_trend_smoother_top; depends on nothing.
package hlts_pkg;

  localparam int OPA_BITS   = 64;
  localparam int MUL_BITS   = 32;
  localparam int PROD_BITS  = 64;
  localparam int ACC_BITS   = 80;
  localparam int GAIN_BITS  = 17;
  localparam int GAIN_FRAC  = 16;
  localparam int SUM_BITS   = 63;
  localparam int COUNT_BITS = 32;
  localparam int UPC_BITS   = 5;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE         = 17'h10000;
  localparam logic [GAIN_BITS-1:0] LEVEL_GAIN_RESET = 17'd26214;
  localparam logic [GAIN_BITS-1:0] TREND_GAIN_RESET = 17'd39322;
  localparam logic [ACC_BITS-1:0]  ROUND_HALF       = ACC_BITS'(32768);

  // Register indexes on the configuration port (paddr[2]).
  localparam logic REG_LEVEL_GAIN = 1'b0;
  localparam logic REG_TREND_GAIN = 1'b1;

  // Sequencer jump kinds.
  localparam logic [1:0] J_NEXT     = 2'd0;
  localparam logic [1:0] J_GOTO     = 2'd1;
  localparam logic [1:0] J_DISPATCH = 2'd2;
  localparam logic [1:0] J_EMIT     = 2'd3;

  // Datapath operations.
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_FIRST  = 4'd1;
  localparam logic [3:0] OP_SECOND = 4'd2;
  localparam logic [3:0] OP_FC     = 4'd3;
  localparam logic [3:0] OP_FCINT  = 4'd4;
  localparam logic [3:0] OP_ERR    = 4'd5;
  localparam logic [3:0] OP_T1     = 4'd6;
  localparam logic [3:0] OP_NL     = 4'd7;
  localparam logic [3:0] OP_TREND  = 4'd8;
  localparam logic [3:0] OP_SCORE  = 4'd9;

  // Multiplier operand loads.
  localparam logic [2:0] LD_NONE  = 3'd0;
  localparam logic [2:0] LD_XF    = 3'd1;
  localparam logic [2:0] LD_FC    = 3'd2;
  localparam logic [2:0] LD_STEP  = 3'd3;
  localparam logic [2:0] LD_TREND = 3'd4;
  localparam logic [2:0] LD_ERR   = 3'd5;

  // Multiplier and accumulator operations.
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LO   = 2'd1;
  localparam logic [1:0] MUL_HI   = 2'd2;
  localparam logic [1:0] MUL_SQ   = 2'd3;

  localparam logic [1:0] ACC_NONE     = 2'd0;
  localparam logic [1:0] ACC_LOAD     = 2'd1;
  localparam logic [1:0] ACC_LOAD_RND = 2'd2;
  localparam logic [1:0] ACC_ADD_HI   = 2'd3;

  // Program entry points.
  localparam logic [UPC_BITS-1:0] UPC_WAIT   = 5'd0;
  localparam logic [UPC_BITS-1:0] UPC_FIRST  = 5'd1;
  localparam logic [UPC_BITS-1:0] UPC_SECOND = 5'd2;
  localparam logic [UPC_BITS-1:0] UPC_RUN    = 5'd3;
  localparam logic [UPC_BITS-1:0] UPC_EMIT   = 5'd18;

  typedef struct packed {
    logic [1:0] mul_op;
    logic [1:0] acc_op;
  } mul_ctrl_t;

  typedef struct packed {
    logic [1:0]          jump;
    logic [UPC_BITS-1:0] target;
    logic [3:0]          op;
    logic [2:0]          load;
    mul_ctrl_t           mul;
  } ucode_t;

  function automatic ucode_t uword(input logic [1:0] jump, input logic [UPC_BITS-1:0] target,
                                   input logic [3:0] op, input logic [2:0] load,
                                   input logic [1:0] mul_op, input logic [1:0] acc_op);
    ucode_t w;
    w.jump       = jump;
    w.target     = target;
    w.op         = op;
    w.load       = load;
    w.mul.mul_op = mul_op;
    w.mul.acc_op = acc_op;
    return w;
  endfunction

  // Each gain product runs as low half, high half plus rounded load, then the
  // shifted high half is added; the next product overlaps where registers allow.
  function automatic ucode_t ucode_rom(input logic [UPC_BITS-1:0] addr);
    ucode_t w;
    unique case (addr)
      5'd0:  w = uword(J_DISPATCH, UPC_WAIT, OP_NONE,   LD_NONE,  MUL_NONE, ACC_NONE);
      5'd1:  w = uword(J_GOTO,     UPC_EMIT, OP_FIRST,  LD_NONE,  MUL_NONE, ACC_NONE);
      5'd2:  w = uword(J_GOTO,     UPC_EMIT, OP_SECOND, LD_NONE,  MUL_NONE, ACC_NONE);
      5'd3:  w = uword(J_NEXT,     UPC_WAIT, OP_FC,     LD_XF,    MUL_NONE, ACC_NONE);
      5'd4:  w = uword(J_NEXT,     UPC_WAIT, OP_FCINT,  LD_NONE,  MUL_LO,   ACC_NONE);
      5'd5:  w = uword(J_NEXT,     UPC_WAIT, OP_ERR,    LD_FC,    MUL_HI,   ACC_LOAD_RND);
      5'd6:  w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_LO,   ACC_ADD_HI);
      5'd7:  w = uword(J_NEXT,     UPC_WAIT, OP_T1,     LD_NONE,  MUL_HI,   ACC_LOAD_RND);
      5'd8:  w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_NONE, ACC_ADD_HI);
      5'd9:  w = uword(J_NEXT,     UPC_WAIT, OP_NL,     LD_NONE,  MUL_NONE, ACC_NONE);
      5'd10: w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_STEP,  MUL_NONE, ACC_NONE);
      5'd11: w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_LO,   ACC_NONE);
      5'd12: w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_TREND, MUL_HI,   ACC_LOAD_RND);
      5'd13: w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_LO,   ACC_ADD_HI);
      5'd14: w = uword(J_NEXT,     UPC_WAIT, OP_T1,     LD_ERR,   MUL_HI,   ACC_LOAD_RND);
      5'd15: w = uword(J_NEXT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_SQ,   ACC_ADD_HI);
      5'd16: w = uword(J_NEXT,     UPC_WAIT, OP_TREND,  LD_NONE,  MUL_NONE, ACC_LOAD);
      5'd17: w = uword(J_NEXT,     UPC_WAIT, OP_SCORE,  LD_NONE,  MUL_NONE, ACC_NONE);
      5'd18: w = uword(J_EMIT,     UPC_WAIT, OP_NONE,   LD_NONE,  MUL_NONE, ACC_NONE);
      default: w = uword(J_GOTO,   UPC_WAIT, OP_NONE,   LD_NONE,  MUL_NONE, ACC_NONE);
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/holt_linear_trend_smoother_top.sv =====
// Top level of the Holt linear-trend smoother: microcode sequencer and datapath.
// Depends on hlts_pkg (types, codes, microcode table) and hlts_mul_unit.
//
// Usage. Samples arrive on the s_ stream: s_tdata carries the signed sample and
// s_tuser the restart flag, which begins a new series and clears the running
// totals. Each accepted transaction yields exactly one result transaction on
// the m_ stream: m_tdata carries the rounded forecast, the forecast error, the
// saturating sum of squared errors and the saturating scored count; m_tuser
// says whether a forecast existed for the sample. The smoothing gains sit
// behind an APB port at byte addresses 0 and 4; the user must write them only
// while idle, as the block itself does not enforce this.
// Timing. One sample is worked on at a time. The first and second samples of
// a series take a shorter path; every later sample runs five products, four
// gain products in two 32-bit halves each plus the squared error, through the
// single shared 32x32 multiplier under control of the microcode table.
// Stalls. The result sits in an output register; the next sample is taken
// while it waits, and the sequencer only holds at its final step if the
// previous result has still not been taken. Reset restores the default gains,
// clears level, trend, totals and the series phase, and empties the output.
module holt_linear_trend_smoother_top
  import hlts_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // sample
  input  logic                      s_tuser,   // restart
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [OUT_TDATA_BITS-1:0] m_tdata,   // forecast, forecast_error,
                                               // squared_error_sum, scored_count
  output logic                      m_tuser,   // forecast_valid
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int FC_BITS        = SAMPLE_BITS + 2;
  localparam int ERR_BITS       = SAMPLE_BITS + 3;
  localparam int OUT_FIELD_BITS = FC_BITS + ERR_BITS + SUM_BITS + COUNT_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int STATE_RAW      = SAMPLE_BITS + FRACTION_BITS + 8;
  localparam int STATE_BITS     = (STATE_RAW > 62) ? 62 : STATE_RAW;
  // Working width for sums and differences of two state values.
  localparam int CW             = STATE_BITS + 3;

  localparam logic signed [CW-1:0] STATE_HI =
    {{(CW - STATE_BITS + 1){1'b0}}, {(STATE_BITS - 1){1'b1}}};
  localparam logic signed [CW-1:0] STATE_LO = ~STATE_HI;
  localparam logic signed [CW-1:0] FC_HI =
    {{(CW - FC_BITS + 1){1'b0}}, {(FC_BITS - 1){1'b1}}};
  localparam logic signed [CW-1:0] FC_LO = ~FC_HI;
  localparam logic [CW-1:0] RND_HALF = CW'(1) << (FRACTION_BITS - 1);

  // Series phase: nothing seen, level set, running.
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_LEVEL = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  function automatic logic signed [CW-1:0] sxs(input logic signed [STATE_BITS-1:0] v);
    return {{3{v[STATE_BITS-1]}}, v};
  endfunction

  function automatic logic [CW-1:0] absw(input logic signed [CW-1:0] v);
    return v[CW-1] ? unsigned'(-v) : unsigned'(v);
  endfunction

  function automatic logic signed [STATE_BITS-1:0] clamp_state(input logic signed [CW-1:0] v);
    if (v > STATE_HI) begin
      return STATE_HI[STATE_BITS-1:0];
    end else if (v < STATE_LO) begin
      return STATE_LO[STATE_BITS-1:0];
    end else begin
      return v[STATE_BITS-1:0];
    end
  endfunction

  function automatic logic signed [FC_BITS-1:0] clamp_fc(input logic signed [CW-1:0] v);
    if (v > FC_HI) begin
      return FC_HI[FC_BITS-1:0];
    end else if (v < FC_LO) begin
      return FC_LO[FC_BITS-1:0];
    end else begin
      return v[FC_BITS-1:0];
    end
  endfunction

  // Configuration registers and their effective values (above 1.0 acts as 1.0).
  logic [GAIN_BITS-1:0] level_gain;
  logic [GAIN_BITS-1:0] trend_gain;
  logic [GAIN_BITS-1:0] alpha;
  logic [GAIN_BITS-1:0] beta;

  // Sequencer.
  logic [UPC_BITS-1:0] upc;
  logic [UPC_BITS-1:0] entry;
  ucode_t              uc;
  logic                in_fire;
  logic                out_free;
  logic                emit_fire;

  // Series state and per-sample registers.
  logic [1:0]                   phase;
  logic signed [STATE_BITS-1:0] level;
  logic signed [STATE_BITS-1:0] trend;
  logic signed [STATE_BITS-1:0] fc;
  logic signed [STATE_BITS-1:0] nl;
  logic signed [CW-1:0]         t1;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [FC_BITS-1:0]    fc_int;
  logic signed [ERR_BITS-1:0]   err;
  logic                         fvalid;
  logic [SUM_BITS-1:0]          error_sum;
  logic [COUNT_BITS-1:0]        count;

  // Multiplier operands and results.
  logic [OPA_BITS-1:0]  mag;
  logic                 mag_neg;
  logic [GAIN_BITS-1:0] gain;
  logic [ACC_BITS-1:0]  acc;
  logic                 acc_neg;

  // Datapath intermediates.
  logic signed [STATE_BITS-1:0] xf;
  logic signed [CW-1:0]         xf_w;
  logic signed [CW-1:0]         step_w;
  logic signed [CW-1:0]         err_w;
  logic [CW-1:0]                fc_mag;
  logic [CW-1:0]                fc_round;
  logic signed [CW-1:0]         fc_round_s;
  logic [STATE_BITS:0]          gain_mag;
  logic signed [CW-1:0]         gain_res;
  logic [SUM_BITS-1:0]          sq_val;
  logic [SUM_BITS:0]            sum_ext;

  assign pready = 1'b1;
  assign alpha  = (level_gain > GAIN_ONE) ? GAIN_ONE : level_gain;
  assign beta   = (trend_gain > GAIN_ONE) ? GAIN_ONE : trend_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_gain <= LEVEL_GAIN_RESET;
      trend_gain <= TREND_GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LEVEL_GAIN: level_gain <= pwdata[GAIN_BITS-1:0];
        REG_TREND_GAIN: trend_gain <= pwdata[GAIN_BITS-1:0];
        default:        level_gain <= level_gain;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_LEVEL_GAIN: prdata = 32'(level_gain);
      REG_TREND_GAIN: prdata = 32'(trend_gain);
      default:        prdata = '0;
    endcase
  end

  // The control word of the current step drives everything below.
  assign uc        = ucode_rom(upc);
  assign s_tready  = (uc.jump == J_DISPATCH);
  assign in_fire   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign emit_fire = (uc.jump == J_EMIT) && out_free;

  // A restart always takes the path of the first sample of a series.
  always_comb begin
    if (s_tuser) begin
      entry = UPC_FIRST;
    end else begin
      unique case (phase)
        PH_EMPTY: entry = UPC_FIRST;
        PH_LEVEL: entry = UPC_SECOND;
        default:  entry = UPC_RUN;
      endcase
    end
  end

  assign xf     = {{(STATE_BITS - SAMPLE_BITS - FRACTION_BITS){x[SAMPLE_BITS-1]}}, x,
                   {FRACTION_BITS{1'b0}}};
  assign xf_w   = sxs(xf);
  assign step_w = sxs(nl) - sxs(level);
  assign err_w  = {{(CW - ERR_BITS){err[ERR_BITS-1]}}, err};

  // Forecast to integer, rounding half away from zero.
  assign fc_mag     = absw(sxs(fc));
  assign fc_round   = (fc_mag + RND_HALF) >> FRACTION_BITS;
  assign fc_round_s = fc[STATE_BITS-1] ? -signed'(fc_round) : signed'(fc_round);

  // Rounded gain product with its sign restored.
  assign gain_mag = acc[GAIN_FRAC +: STATE_BITS + 1];
  assign gain_res = acc_neg ? -signed'(CW'(gain_mag)) : signed'(CW'(gain_mag));

  // A square whose root is 2^32 or more, or that spills into bit 63, saturates.
  assign sq_val  = ((|mag[OPA_BITS-1:MUL_BITS]) || acc[SUM_BITS]) ? '1 : acc[SUM_BITS-1:0];
  assign sum_ext = {1'b0, error_sum} + {1'b0, sq_val};

  hlts_mul_unit u_mul (
    .clk     (clk),
    .ctrl    (uc.mul),
    .opa     (mag),
    .opa_neg (mag_neg),
    .gain    (gain),
    .acc     (acc),
    .acc_neg (acc_neg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= UPC_WAIT;
      phase     <= PH_EMPTY;
      level     <= '0;
      trend     <= '0;
      error_sum <= '0;
      count     <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      unique case (uc.jump)
        J_NEXT:     upc <= upc + 1'b1;
        J_GOTO:     upc <= uc.target;
        J_DISPATCH: if (in_fire) begin
          upc <= entry;
        end
        J_EMIT:     if (out_free) begin
          upc <= uc.target;
        end
        default:    upc <= UPC_WAIT;
      endcase

      if (in_fire) begin
        x <= s_tdata[SAMPLE_BITS-1:0];
        if (s_tuser) begin
          error_sum <= '0;
          count     <= '0;
        end
      end

      unique case (uc.load)
        LD_XF: begin
          mag     <= OPA_BITS'(absw(xf_w));
          mag_neg <= xf_w[CW-1];
          gain    <= alpha;
        end
        LD_FC: begin
          mag     <= OPA_BITS'(absw(sxs(fc)));
          mag_neg <= fc[STATE_BITS-1];
          gain    <= GAIN_ONE - alpha;
        end
        LD_STEP: begin
          mag     <= OPA_BITS'(absw(step_w));
          mag_neg <= step_w[CW-1];
          gain    <= beta;
        end
        LD_TREND: begin
          mag     <= OPA_BITS'(absw(sxs(trend)));
          mag_neg <= trend[STATE_BITS-1];
          gain    <= GAIN_ONE - beta;
        end
        LD_ERR: begin
          mag     <= OPA_BITS'(absw(err_w));
          mag_neg <= err_w[CW-1];
        end
        default: begin
          mag <= mag;
        end
      endcase

      unique case (uc.op)
        OP_FIRST: begin
          level  <= xf;
          trend  <= '0;
          phase  <= PH_LEVEL;
          fc_int <= '0;
          err    <= '0;
          fvalid <= 1'b0;
        end
        OP_SECOND: begin
          // The forecast equals the sample, so the error is zero and only the
          // count moves.
          trend  <= clamp_state(xf_w - sxs(level));
          level  <= xf;
          phase  <= PH_RUN;
          fc_int <= {{2{x[SAMPLE_BITS-1]}}, x};
          err    <= '0;
          fvalid <= 1'b1;
          if (!(&count)) begin
            count <= count + 1'b1;
          end
        end
        OP_FC: begin
          fc <= clamp_state(sxs(level) + sxs(trend));
        end
        OP_FCINT: begin
          fc_int <= clamp_fc(fc_round_s);
          fvalid <= 1'b1;
        end
        OP_ERR: begin
          err <= {{3{x[SAMPLE_BITS-1]}}, x} - {fc_int[FC_BITS-1], fc_int};
        end
        OP_T1: begin
          t1 <= gain_res;
        end
        OP_NL: begin
          nl <= clamp_state(t1 + gain_res);
        end
        OP_TREND: begin
          trend <= clamp_state(t1 + gain_res);
          level <= nl;
          phase <= PH_RUN;
        end
        OP_SCORE: begin
          error_sum <= sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
          if (!(&count)) begin
            count <= count + 1'b1;
          end
        end
        default: begin
          fvalid <= fvalid;
        end
      endcase

      if (emit_fire) begin
        m_tvalid <= 1'b1;
        m_tdata  <= OUT_TDATA_BITS'({count, error_sum, err, fc_int});
        m_tuser  <= fvalid;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/hlts_mul_unit.sv =====
// Shared 32x32 multiplier with product register and rounding accumulator.
// Depends on hlts_pkg for the control struct and the operation codes.
module hlts_mul_unit
  import hlts_pkg::*;
(
  input  logic                 clk,
  input  mul_ctrl_t            ctrl,
  input  logic [OPA_BITS-1:0]  opa,
  input  logic                 opa_neg,
  input  logic [GAIN_BITS-1:0] gain,
  output logic [ACC_BITS-1:0]  acc,
  output logic                 acc_neg
);

  logic [MUL_BITS-1:0]  mul_a;
  logic [MUL_BITS-1:0]  mul_b;
  logic [PROD_BITS-1:0] prod;

  always_comb begin
    unique case (ctrl.mul_op)
      MUL_LO: begin
        mul_a = opa[MUL_BITS-1:0];
        mul_b = MUL_BITS'(gain);
      end
      MUL_HI: begin
        mul_a = opa[OPA_BITS-1:MUL_BITS];
        mul_b = MUL_BITS'(gain);
      end
      MUL_SQ: begin
        mul_a = opa[MUL_BITS-1:0];
        mul_b = opa[MUL_BITS-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_op != MUL_NONE) begin
      prod <= mul_a * mul_b;
    end
    // The sign follows the operand into the product so a new operand may load early.
    if (ctrl.mul_op == MUL_HI) begin
      acc_neg <= opa_neg;
    end
    case (ctrl.acc_op)
      ACC_LOAD:     acc <= ACC_BITS'(prod);
      ACC_LOAD_RND: acc <= ACC_BITS'(prod) + ROUND_HALF;
      ACC_ADD_HI:   acc <= acc + ACC_BITS'({prod, {MUL_BITS{1'b0}}});
      default:      acc <= acc;
    endcase
  end

endmodule
